[src/assert_macros.svh]
// Assertion helpers, included by modem_bringup_sequencer_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop at every rising edge of clk, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

[src/mbs_pkg.sv]
package mbs_pkg;

   // Receive window depth in characters
   localparam int WINDOW_CHARS = 13;
   localparam int DIST_W = $clog2(WINDOW_CHARS);
   // Longest response string held in a table entry
   localparam int RESP_CHARS = 13;

   // Request kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_POWER_ON_LEVEL  = 2'd0;
   localparam logic [1:0] REG_STEP_TIMEOUT    = 2'd1;
   localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd2;

   localparam logic [2:0] CMD_TCP_CLOSE = 3'd0;
   localparam logic [2:0] CMD_PIN       = 3'd1;
   localparam logic [2:0] CMD_ECHO_OFF  = 3'd2;
   localparam logic [2:0] CMD_CREG      = 3'd3;
   localparam logic [2:0] CMD_CGATT     = 3'd4;
   localparam logic [2:0] CMD_PPP       = 3'd5;
   localparam logic [2:0] CMD_TCP_TRANS = 3'd6;

   // Strings are right-justified: the last character sits in the low byte.
   localparam logic [8*RESP_CHARS-1:0] STR_OK    = "OK";
   localparam logic [8*RESP_CHARS-1:0] STR_PIN   = "+CPIN: READY";
   localparam logic [8*RESP_CHARS-1:0] STR_CREG  = "+CREG: 0,1";
   localparam logic [8*RESP_CHARS-1:0] STR_CGATT = "+CGATT: 1";
   localparam logic [8*RESP_CHARS-1:0] STR_TCP   = "+TCPTRANS: OK";
   localparam logic [8*RESP_CHARS-1:0] STR_ERR   = "ERROR";
   localparam logic [5:0] ERR_LEN = 6'd5;

   typedef struct packed {
      logic resp;
      logic err;
   } win_hit_type;

   function automatic logic [5:0] resp_len(input logic [2:0] cmd);
      logic [5:0] n;
      case (cmd)
         CMD_PIN:       n = 6'd12;
         CMD_CREG:      n = 6'd10;
         CMD_CGATT:     n = 6'd9;
         CMD_TCP_TRANS: n = 6'd13;
         default:       n = 6'd2;
      endcase
      return n;
   endfunction

   function automatic logic [8*RESP_CHARS-1:0] resp_str(input logic [2:0] cmd);
      logic [8*RESP_CHARS-1:0] s;
      case (cmd)
         CMD_PIN:       s = STR_PIN;
         CMD_CREG:      s = STR_CREG;
         CMD_CGATT:     s = STR_CGATT;
         CMD_TCP_TRANS: s = STR_TCP;
         default:       s = STR_OK;
      endcase
      return s;
   endfunction

   // True when ch agrees with the character tail_pos places from the string
   // end, or when that place lies before the start of the string.
   function automatic logic str_hit(input logic [8*RESP_CHARS-1:0] s,
                                    input logic [5:0] n,
                                    input logic [DIST_W-1:0] tail_pos,
                                    input logic [7:0] ch);
      logic [5:0] d;
      d = 6'(tail_pos);
      if (d >= n) begin
         return 1'b1;
      end
      return ch == s[8*d +: 8];
   endfunction

endpackage

[src/mbs_window_cell.sv]
module mbs_window_cell
   import mbs_pkg::*;
(
   input  logic              clock,
   input  logic              shift_en,
   input  logic              clear,
   input  logic [2:0]        cmd,
   input  logic [DIST_W-1:0] tail_pos,
   input  logic [7:0]        in_char,
   output logic [7:0]        out_char,
   output win_hit_type       hit
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // Clear wins over shift when a new command is issued.
   always_comb begin
      data_in = data_ff;
      if (clear) begin
         data_in = 8'h00;
      end else if (shift_en) begin
         data_in = in_char;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_char = data_ff;

   // Compare the character that moves in on this shift.
   assign hit.resp = str_hit(resp_str(cmd), resp_len(cmd), tail_pos, in_char);
   assign hit.err  = str_hit(STR_ERR, ERR_LEN, tail_pos, in_char);

endmodule

[src/mbs_char_window.sv]
module mbs_char_window
   import mbs_pkg::*;
(
   input  logic        clock,
   input  logic        shift_en,
   input  logic        clear,
   input  logic [2:0]  cmd,
   input  logic [7:0]  rx_char,
   output win_hit_type hit
);

   logic [7:0]  chain_char [WINDOW_CHARS];
   win_hit_type cell_hit   [WINDOW_CHARS];
   logic [WINDOW_CHARS-1:0] resp_bits;
   logic [WINDOW_CHARS-1:0] err_bits;
   logic resp_fits;

   for (genvar i = 0; i < WINDOW_CHARS; i++) begin : g_cell
      logic [7:0] feed;
      if (i == WINDOW_CHARS - 1) begin : g_tail
         assign feed = rx_char;
      end else begin : g_body
         assign feed = chain_char[i+1];
      end

      mbs_window_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .clear    (clear),
         .cmd      (cmd),
         .tail_pos (DIST_W'(WINDOW_CHARS - 1 - i)),
         .in_char  (feed),
         .out_char (chain_char[i]),
         .hit      (cell_hit[i])
      );

      assign resp_bits[i] = cell_hit[i].resp;
      assign err_bits[i]  = cell_hit[i].err;
   end

   // A response longer than the window can never be seen.
   assign resp_fits = resp_len(cmd) <= 6'(WINDOW_CHARS);

   assign hit.resp = resp_fits && (&resp_bits);
   assign hit.err  = &err_bits;

endmodule

[src/modem_bringup_sequencer_unit.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_kind, req_rx_char
// rsp     | out       | rsp_valid / rsp_ready | rsp_command_start, rsp_command_id,
//         |           |                       | rsp_modem_power, rsp_finished
// csr     | in        | csr_wr_en             | csr_index, csr_wr_data
//
// One transaction enters per cycle while req_ready is high; its result is
// registered and shows in the cycle after acceptance. The window compare
// and step control settle in the accepting cycle and never hold intake.
// A stalled result blocks intake only while the output register is still full
// and rsp_ready is low. Synchronous reset returns the sequencer to idle with
// the modem off and the registers at their defaults; no clearing pass.
`include "assert_macros.svh"

module modem_bringup_sequencer_unit
   import mbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_char,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_command_start,
   output logic [2:0] rsp_command_id,
   output logic       rsp_modem_power,
   output logic       rsp_finished,

   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   // Phase: idle, one code per step (command + 1), done
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_FIRST = 4'd1;
   localparam logic [3:0] PH_LAST  = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   // Configuration registers
   logic       pwr_level_ff;
   logic [7:0] step_to_ff;
   logic [7:0] conn_to_ff;

   // Sequencer state
   logic [3:0] phase_ff, phase_in;
   logic       wait_ff,  wait_in;
   logic [7:0] tick_ff,  tick_in;
   logic       power_ff, power_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_start_ff, rsp_start_in;
   logic [2:0] rsp_id_ff,    rsp_id_in;
   logic       rsp_power_ff, rsp_power_in;
   logic       rsp_fin_ff,   rsp_fin_in;

   logic        accept;
   logic        active;
   logic [2:0]  cmd;
   logic        shift_en;
   logic        clear_win;
   win_hit_type hit;
   logic [7:0]  tick_sat;
   logic [7:0]  limit;

   // Take a new transaction whenever the result slot is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign active = (phase_ff >= PH_FIRST) && (phase_ff <= PH_LAST);
   assign cmd    = 3'(phase_ff - 4'd1);

   assign shift_en = accept && (req_kind == KIND_CHAR) && active && !wait_ff;

   mbs_char_window u_window (
      .clock    (clock),
      .shift_en (shift_en),
      .clear    (clear_win),
      .cmd      (cmd),
      .rx_char  (req_rx_char),
      .hit      (hit)
   );

   assign tick_sat = (tick_ff == 8'hFF) ? tick_ff : tick_ff + 8'd1;
   assign limit    = (cmd == CMD_TCP_TRANS) ? conn_to_ff : step_to_ff;

   always_comb begin
      logic       do_end;
      logic       end_ok;
      logic       do_issue;
      logic [2:0] issue_cmd;

      do_end    = 1'b0;
      end_ok    = 1'b0;
      do_issue  = 1'b0;
      issue_cmd = CMD_TCP_CLOSE;

      phase_in = phase_ff;
      wait_in  = wait_ff;
      tick_in  = tick_ff;
      power_in = power_ff;

      if (accept) begin
         case (req_kind)
            KIND_START: begin
               if (phase_ff == PH_IDLE) begin
                  power_in  = 1'b1;
                  do_issue  = 1'b1;
                  issue_cmd = CMD_TCP_CLOSE;
               end
            end
            KIND_CHAR: begin
               if (shift_en) begin
                  // The expected response takes precedence over ERROR.
                  if (hit.resp) begin
                     do_end = 1'b1;
                     end_ok = 1'b1;
                  end else if (hit.err) begin
                     do_end = 1'b1;
                  end
               end
            end
            KIND_TICK: begin
               if (active) begin
                  if (wait_ff) begin
                     // Pause over: power back on after a failed connect, and issue the step's command.
                     if (phase_ff == PH_FIRST) begin
                        power_in = 1'b1;
                     end
                     do_issue  = 1'b1;
                     issue_cmd = cmd;
                  end else begin
                     tick_in = tick_sat;
                     if (tick_sat >= limit) begin
                        do_end = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_end) begin
         case (cmd)
            CMD_TCP_CLOSE: begin
               // Result ignored: go straight on to the PIN check.
               do_issue  = 1'b1;
               issue_cmd = CMD_PIN;
            end
            CMD_TCP_TRANS: begin
               if (end_ok) begin
                  phase_in = PH_DONE;
                  wait_in  = 1'b0;
               end else begin
                  power_in = 1'b0;
                  phase_in = PH_FIRST;
                  wait_in  = 1'b1;
               end
            end
            default: begin
               if (end_ok) begin
                  phase_in = phase_ff + 4'd1;
               end
               wait_in = 1'b1;
            end
         endcase
      end

      if (do_issue) begin
         phase_in = {1'b0, issue_cmd} + 4'd1;
         tick_in  = 8'h00;
         wait_in  = 1'b0;
      end

      clear_win = do_issue;

      // Load the result register on acceptance, drop it once taken.
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_power_in = rsp_power_ff;
      rsp_fin_in   = rsp_fin_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = do_issue;
         rsp_id_in    = do_issue ? issue_cmd : CMD_TCP_CLOSE;
         rsp_power_in = power_in ? pwr_level_ff : !pwr_level_ff;
         rsp_fin_in   = (phase_in == PH_DONE);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_level_ff <= 1'b1;
         step_to_ff   <= 8'd2;
         conn_to_ff   <= 8'd5;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_POWER_ON_LEVEL:  pwr_level_ff <= csr_wr_data[0];
            REG_STEP_TIMEOUT:    step_to_ff   <= csr_wr_data;
            REG_CONNECT_TIMEOUT: conn_to_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= 1'b0;
         tick_ff      <= 8'h00;
         power_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         tick_ff      <= tick_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload holds no reset.
   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_power_ff <= rsp_power_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command_start = rsp_start_ff;
   assign rsp_command_id    = rsp_id_ff;
   assign rsp_modem_power   = rsp_power_ff;
   assign rsp_finished      = rsp_fin_ff;

   // A pending pause exists only inside an active step.
   `ASSERT_CLK_RST(a_wait_in_step, clock, reset,
      wait_ff |-> (phase_ff >= PH_FIRST && phase_ff <= PH_LAST))
   // Done is sticky until reset.
   `ASSERT_CLK_RST(a_done_sticky, clock, reset,
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
   // A finished result implies the sequencer reached done.
   `ASSERT_CLK_RST(a_fin_done, clock, reset,
      (rsp_valid_ff && rsp_fin_ff) |-> phase_ff == PH_DONE)
   // No command id without a command strobe.
   `ASSERT_CLK_RST(a_id_quiet, clock, reset,
      (rsp_valid_ff && !rsp_start_ff) |-> rsp_id_ff == CMD_TCP_CLOSE)

endmodule
